@@ sv/pfba_pkg.sv @@
// ----------------------------------------------------------------------------
// pfba_pkg
// shared types and constants of the page frame bitmap allocator
// ----------------------------------------------------------------------------
package pfba_pkg;

	localparam int HEAP_FRAMES_DEF = 256;
	localparam int BATCH_SIZE_DEF  = 20;

	// frame size is fixed, so the index math is a shift
	localparam int FRAME_BYTES = 4096;
	localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);

	localparam logic [31:0] HEAP_BASE_RST = 32'h0010_0000;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef struct packed {
		logic        opcode;
		logic [31:0] free_address;
	} request_t;

	typedef struct packed {
		logic [31:0] frame_address;
		logic        out_of_frames;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FREE_RD,
		ST_FREE_WR,
		ST_SCAN_RD,
		ST_SCAN_EVAL,
		ST_BATCH_RD,
		ST_BATCH_OUT
	} back_state_t;

	typedef struct packed {
		logic in_clear;
	} back_status_t;

endpackage

@@ sv/pfba_front.sv @@
// ----------------------------------------------------------------------------
// pfba_front
// request intake: classifies requests and turns free addresses into indices
// ----------------------------------------------------------------------------
module pfba_front #(
	parameter int HEAP_FRAMES = pfba_pkg::HEAP_FRAMES_DEF
) (
	input  logic              start,
	input  logic              busy,
	input  pfba_pkg::request_t request,
	input  logic [31:0]       heap_base,
	output logic              push,
	output pfba_pkg::op_t     cmd_op,
	output logic [((((HEAP_FRAMES + 7) / 8) > 1) ? $clog2((HEAP_FRAMES + 7) / 8) : 1) + 2:0] cmd_idx
);
	import pfba_pkg::*;

	localparam int ROWS  = (HEAP_FRAMES + 7) / 8;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IDX_W = ROW_W + 3;
	localparam int QW    = 32 - FRAME_SHIFT;

	logic [31:0]   offset;
	logic [QW-1:0] quot;
	logic          in_range;

	assign offset   = request.free_address - heap_base;
	assign quot     = offset[31:FRAME_SHIFT];
	// below the base or past the last frame: dropped here
	assign in_range = (request.free_address >= heap_base) && (quot < QW'(HEAP_FRAMES));

	assign cmd_op  = op_t'(request.opcode);
	assign cmd_idx = quot[IDX_W-1:0];
	assign push    = start && !busy && ((cmd_op == OP_ALLOC) || in_range);

endmodule

@@ sv/pfba_queue.sv @@
// ----------------------------------------------------------------------------
// pfba_queue
// two-entry command queue between intake and engine
// ----------------------------------------------------------------------------
module pfba_queue #(
	parameter int DATA_W = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wdata,
	input  logic              pop,
	output logic [DATA_W-1:0] rdata,
	output logic              full,
	output logic              empty
);
	import pfba_pkg::*;

	logic [DATA_W-1:0] entry_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rdata = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

@@ sv/pfba_back.sv @@
// ----------------------------------------------------------------------------
// pfba_back
// allocation engine: bitmap memory, batch memory, refill scan and frees
// ----------------------------------------------------------------------------
module pfba_back #(
	parameter int HEAP_FRAMES = pfba_pkg::HEAP_FRAMES_DEF,
	parameter int BATCH_SIZE  = pfba_pkg::BATCH_SIZE_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [31:0]            heap_base,
	input  logic                   q_empty,
	input  logic [((((HEAP_FRAMES + 7) / 8) > 1) ? $clog2((HEAP_FRAMES + 7) / 8) : 1) + 3:0] q_rdata,
	output logic                   q_pop,
	output logic                   result_valid,
	output pfba_pkg::result_t      result,
	output pfba_pkg::back_status_t status
);
	import pfba_pkg::*;

	localparam int ROWS   = (HEAP_FRAMES + 7) / 8;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IDX_W  = ROW_W + 3;
	localparam int BIDX_W = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;
	localparam int PAD_SH = HEAP_FRAMES - (ROWS - 1) * 8;
	localparam logic [7:0]        LAST_PAD = 8'hFF << PAD_SH;
	localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
	localparam logic [BIDX_W-1:0] LAST_B   = BIDX_W'(BATCH_SIZE - 1);

	function automatic logic [2:0] low_zero(input logic [7:0] w);
		logic [2:0] r;
		r = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (!w[i]) begin
				r = 3'(i);
			end
		end
		return r;
	endfunction

	// memories
	logic [7:0]       bmap_mem [ROWS];
	logic [IDX_W-1:0] batch_mem [BATCH_SIZE];
	logic [7:0]       bm_rdata_q;
	logic [IDX_W-1:0] bt_rdata_q;

	back_state_t      state_q, state_d;
	logic [ROW_W-1:0] row_q, row_d;
	logic [2:0]       bit_q, bit_d;
	logic [7:0]       word_q, word_d;
	logic             first_q, first_d;
	logic [BIDX_W-1:0] fill_q, fill_d;
	logic [BIDX_W-1:0] pos_q, pos_d;
	logic             pend_q, pend_d;
	logic             res_valid_q, res_valid_d;
	result_t          result_q, result_d;

	logic             bm_we;
	logic [7:0]       bm_wdata;
	logic             bt_we;
	logic [7:0]       pad;
	logic [7:0]       cur_word;
	logic [7:0]       new_word;
	logic [2:0]       lz;
	op_t              q_op;
	logic [IDX_W-1:0] q_idx;

	assign q_op  = op_t'(q_rdata[IDX_W]);
	assign q_idx = q_rdata[IDX_W-1:0];

	assign pad      = (row_q == LAST_ROW) ? LAST_PAD : 8'h00;
	assign cur_word = first_q ? (bm_rdata_q | pad) : word_q;
	assign lz       = low_zero(cur_word);
	assign new_word = cur_word | (8'h01 << lz);

	always_comb begin
		state_d     = state_q;
		row_d       = row_q;
		bit_d       = bit_q;
		word_d      = word_q;
		first_d     = first_q;
		fill_d      = fill_q;
		pos_d       = pos_q;
		pend_d      = pend_q;
		res_valid_d = 1'b0;
		result_d    = result_q;
		q_pop       = 1'b0;
		bm_we       = 1'b0;
		bm_wdata    = 8'h00;
		bt_we       = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				bm_we = 1'b1;
				if (row_q == LAST_ROW) begin
					state_d = ST_IDLE;
				end else begin
					row_d = row_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (q_op == OP_FREE) begin
						row_d   = q_idx[IDX_W-1:3];
						bit_d   = q_idx[2:0];
						state_d = ST_FREE_RD;
					end else if (pend_q) begin
						row_d   = '0;
						fill_d  = '0;
						first_d = 1'b1;
						state_d = ST_SCAN_RD;
					end else begin
						state_d = ST_BATCH_RD;
					end
				end
			end
			ST_FREE_RD: begin
				state_d = ST_FREE_WR;
			end
			ST_FREE_WR: begin
				bm_we    = 1'b1;
				bm_wdata = bm_rdata_q & ~(8'h01 << bit_q);
				state_d  = ST_IDLE;
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_EVAL;
			end
			ST_SCAN_EVAL: begin
				if (cur_word != 8'hFF) begin
					bm_we    = 1'b1;
					bm_wdata = new_word;
					word_d   = new_word;
					first_d  = 1'b0;
					bt_we    = 1'b1;
					if (fill_q == LAST_B) begin
						pend_d  = 1'b0;
						pos_d   = '0;
						state_d = ST_BATCH_RD;
					end else begin
						fill_d = fill_q + 1'b1;
					end
				end else if (row_q == LAST_ROW) begin
					// bitmap full: fail, claimed frames stay marked
					res_valid_d            = 1'b1;
					result_d.frame_address = 32'h0;
					result_d.out_of_frames = 1'b1;
					state_d                = ST_IDLE;
				end else begin
					row_d   = row_q + 1'b1;
					first_d = 1'b1;
					state_d = ST_SCAN_RD;
				end
			end
			ST_BATCH_RD: begin
				state_d = ST_BATCH_OUT;
			end
			ST_BATCH_OUT: begin
				res_valid_d            = 1'b1;
				result_d.frame_address = heap_base + (32'(bt_rdata_q) << FRAME_SHIFT);
				result_d.out_of_frames = 1'b0;
				if (pos_q == LAST_B) begin
					pend_d = 1'b1;
				end else begin
					pos_d = pos_q + 1'b1;
				end
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			row_q       <= '0;
			first_q     <= 1'b0;
			fill_q      <= '0;
			pos_q       <= '0;
			pend_q      <= 1'b1;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			row_q       <= row_d;
			first_q     <= first_d;
			fill_q      <= fill_d;
			pos_q       <= pos_d;
			pend_q      <= pend_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		bit_q    <= bit_d;
		word_q   <= word_d;
		result_q <= result_d;
	end

	always_ff @(posedge clk) begin
		if (bm_we) begin
			bmap_mem[row_q] <= bm_wdata;
		end
		bm_rdata_q <= bmap_mem[row_q];
	end

	always_ff @(posedge clk) begin
		if (bt_we) begin
			batch_mem[fill_q] <= {row_q, lz};
		end
		bt_rdata_q <= batch_mem[pos_q];
	end

	assign result_valid    = res_valid_q;
	assign result          = result_q;
	assign status.in_clear = (state_q == ST_CLEAR);

endmodule

@@ sv/page_frame_bitmap_allocator.sv @@
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// page frame allocator with a used-bit map and a prefetched batch of frames
// ----------------------------------------------------------------------------
// batch alloc: queued, popped at idle, batch entry read, result register strobes;
//   refill alloc first reads bitmap rows of 8 bits, claiming free bits into the batch
// engine: one request per pass; the queue takes new requests while a pass runs
// free: no result, bitmap row read then rewritten; out-of-range frees dropped at intake
// reset: clearing pass zeroes every bitmap row, busy held high
// results are strobed for one cycle; the receiver cannot stall
module page_frame_bitmap_allocator #(
	parameter int HEAP_FRAMES = pfba_pkg::HEAP_FRAMES_DEF,
	parameter int BATCH_SIZE  = pfba_pkg::BATCH_SIZE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  pfba_pkg::request_t request,
	output logic               busy,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data,
	output logic               result_valid,
	output pfba_pkg::result_t  result
);
	import pfba_pkg::*;

	localparam int ROWS  = (HEAP_FRAMES + 7) / 8;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IDX_W = ROW_W + 3;

	// heap base register
	logic [31:0] heap_base_q;

	// front to queue
	logic             push;
	op_t              cmd_op;
	logic [IDX_W-1:0] cmd_idx;

	// queue to back
	logic [IDX_W:0] q_rdata;
	logic           q_pop;
	logic           q_full;
	logic           q_empty;

	back_status_t bk_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q <= HEAP_BASE_RST;
		end else if (cfg_wr_en) begin
			heap_base_q <= cfg_wr_data;
		end
	end

	// no request taken while the queue is full or the bitmap is being cleared
	assign busy = q_full || bk_status.in_clear;

	// intake: decode request, drop frees that miss the heap
	pfba_front #(
		.HEAP_FRAMES(HEAP_FRAMES)
	) u_front (
		.start    (start),
		.busy     (busy),
		.request  (request),
		.heap_base(heap_base_q),
		.push     (push),
		.cmd_op   (cmd_op),
		.cmd_idx  (cmd_idx)
	);

	// short queue so intake and engine stall independently
	pfba_queue #(
		.DATA_W(IDX_W + 1)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata ({cmd_op, cmd_idx}),
		.pop   (q_pop),
		.rdata (q_rdata),
		.full  (q_full),
		.empty (q_empty)
	);

	// engine: bitmap scan, batch handout, frees
	pfba_back #(
		.HEAP_FRAMES(HEAP_FRAMES),
		.BATCH_SIZE (BATCH_SIZE)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.heap_base   (heap_base_q),
		.q_empty     (q_empty),
		.q_rdata     (q_rdata),
		.q_pop       (q_pop),
		.result_valid(result_valid),
		.result      (result),
		.status      (bk_status)
	);

	// engine returns to idle after every result, so strobes never abut
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("back-to-back result strobes");

	// a failed alloc always reports a null address
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.out_of_frames) |-> (result.frame_address == 32'h0))
		else $error("failed alloc with nonzero address");

	// nothing leaves the queue or the engine while the bitmap is cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		bk_status.in_clear |-> (!q_pop && !result_valid))
		else $error("engine active during clearing pass");

	// a request is never pushed into a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("queue overflow");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the page frame bitmap allocator
//
// a short table of directed requests runs first at the reset heap base, then
// random phases under different heap bases and sender idling. every accepted
// request goes through a bench-side model of the used map and the prefetched
// batch, and each result strobe is checked against the oldest expectation.
// ----------------------------------------------------------------------------
module tb;
	import pfba_pkg::*;

	localparam int FRAMES   = HEAP_FRAMES_DEF;
	localparam int BATCH    = BATCH_SIZE_DEF;
	localparam int MAP_ROWS = FRAMES / 8;
	localparam int DIR_ROWS = 16;

	// one directed request, with the result pinned where it is obvious
	typedef struct {
		op_t         op;
		logic [31:0] addr;
		bit          pinned;
		logic [31:0] want_addr;
		logic        want_oof;
	} directed_row_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        start       = 1'b0;
	request_t    request     = '0;
	logic        busy;
	logic        cfg_wr_en   = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic        result_valid;
	result_t     result;

	// pinned expectation travels with the request so it is sampled at accept
	bit          pin_valid   = 1'b0;
	result_t     pin_result  = '0;

	// bench copy of the allocator state
	logic [31:0] model_base;
	logic [7:0]  model_used [MAP_ROWS];
	logic [7:0]  model_batch [BATCH];
	logic [4:0]  model_pos;
	bit          model_refill;

	result_t     expected_results [$];
	logic [7:0]  live_frames [$];      // frames handed out and not yet freed here

	int sender_idle_pct = 0;
	int allocs_taken    = 0;
	int frees_taken     = 0;
	int oof_predicted   = 0;
	int results_checked = 0;
	int mismatches      = 0;

	directed_row_t plan [DIR_ROWS];

	page_frame_bitmap_allocator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.request      (request),
		.busy         (busy),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.result_valid (result_valid),
		.result       (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// hard stop in case the block hangs
	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	// lowest clear bit of the used map, claimed on the spot
	function automatic bit claim_lowest_free(output logic [7:0] idx);
		int f;
		for (f = 0; f < FRAMES; f++) begin
			if (!model_used[f / 8][f % 8]) begin
				model_used[f / 8][f % 8] = 1'b1;
				idx = 8'(f);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// advances the bench state by one request; returns 1 when a result is due
	function automatic bit model_request(input request_t rq, output result_t res);
		logic [31:0] offs;
		logic [7:0]  idx;
		int          i;
		res = '0;
		if (rq.opcode == OP_FREE) begin
			// below the base or past the last frame: dropped
			if (rq.free_address >= model_base) begin
				offs = rq.free_address - model_base;
				if ((offs >> FRAME_SHIFT) < FRAMES) begin
					idx = offs[FRAME_SHIFT +: 8];
					model_used[idx[7:3]][idx[2:0]] = 1'b0;
				end
			end
			return 1'b0;
		end
		if (model_pos >= BATCH)
			model_refill = 1'b1;
		if (model_refill) begin
			for (i = 0; i < BATCH; i++) begin
				// map filled mid refill: claimed frames stay marked, refill retried later
				if (!claim_lowest_free(idx)) begin
					res.frame_address = '0;
					res.out_of_frames = 1'b1;
					oof_predicted++;
					return 1'b1;
				end
				model_batch[i] = idx;
			end
			model_pos    = '0;
			model_refill = 1'b0;
		end
		idx = model_batch[model_pos];
		res.frame_address = model_base + (32'(idx) << FRAME_SHIFT);
		res.out_of_frames = 1'b0;
		model_pos++;
		live_frames.push_back(idx);
		return 1'b1;
	endfunction

	// prediction at accept, checking at each result strobe
	always @(posedge clk) begin : scoreboard
		result_t predicted;
		result_t want;
		bit      gives;
		int      r;
		if (!arst_n) begin
			model_base   = HEAP_BASE_RST;
			model_pos    = '0;
			model_refill = 1'b1;
			for (r = 0; r < MAP_ROWS; r++)
				model_used[r] = '0;
			for (r = 0; r < BATCH; r++)
				model_batch[r] = '0;
		end else begin
			if (cfg_wr_en)
				model_base = cfg_wr_data;
			if (start && !busy) begin
				if (request.opcode == OP_FREE)
					frees_taken++;
				else
					allocs_taken++;
				gives = model_request(request, predicted);
				if (gives)
					expected_results.push_back(pin_valid ? pin_result : predicted);
			end
			if (result_valid) begin
				results_checked++;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h / %b",
						result.frame_address, result.out_of_frames));
				end else begin
					want = expected_results.pop_front();
					if (result.frame_address !== want.frame_address)
						report_mismatch($sformatf("frame_address got %h want %h",
							result.frame_address, want.frame_address));
					if (result.out_of_frames !== want.out_of_frames)
						report_mismatch($sformatf("out_of_frames got %b want %b",
							result.out_of_frames, want.out_of_frames));
				end
			end
		end
	end

	// one request; returns at the edge that accepts it, start left high
	task automatic send_request(input op_t op, input logic [31:0] addr,
			input bit pinned, input result_t want);
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		request    <= '{opcode: op, free_address: addr};
		pin_valid  <= pinned;
		pin_result <= want;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// sender stops until every result is in and the engine has gone quiet
	task automatic wait_drained(input int tail);
		int n;
		start <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		// a trailing free gives no result but may still hold the engine
		for (n = 0; n < tail; n++)
			@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic write_heap_base(input logic [31:0] value);
		wait_drained(8);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		@(posedge clk);
	endtask

	// allocs and frees, the frees mostly of frames really handed out, plus noise frees
	task automatic send_random_item(input int free_pct);
		logic [31:0] addr;
		logic [7:0]  idx;
		int          pick;
		int          k;
		if ($urandom_range(99) >= free_pct) begin
			send_request(OP_ALLOC, $urandom, 1'b0, '0);
			return;
		end
		pick = $urandom_range(9);
		if (pick < 7 && live_frames.size() != 0) begin
			k    = $urandom_range(live_frames.size() - 1);
			idx  = live_frames[k];
			live_frames.delete(k);
			addr = model_base + (32'(idx) << FRAME_SHIFT);
			// sometimes an unaligned byte inside the frame
			if ($urandom_range(3) == 0)
				addr = addr + 32'($urandom_range(FRAME_BYTES - 1));
		end else begin
			case (pick)
				// any frame: may be free already or still waiting in the batch
				7: addr = model_base + (32'($urandom_range(FRAMES - 1)) << FRAME_SHIFT)
					+ 32'($urandom_range(FRAME_BYTES - 1));
				// just below the base
				8: addr = model_base - 32'd1 - 32'($urandom_range(FRAME_BYTES));
				// past the last frame
				9: addr = model_base + 32'(FRAMES * FRAME_BYTES)
					+ 32'($urandom_range(65535));
				default: addr = $urandom;
			endcase
		end
		send_request(OP_FREE, addr, 1'b0, '0);
	endtask

	task automatic run_phase(input int items, input int idle_pct, input int free_pct,
			input int pause_at);
		int n;
		sender_idle_pct = idle_pct;
		for (n = 0; n < items; n++) begin
			if (n == pause_at)
				wait_drained(0);
			send_random_item(free_pct);
		end
	endtask

	initial begin : stimulus
		int      r;
		int      oof_goal;
		result_t want;

		// reset heap base 0x0010_0000, frames 0..19 prefetched on the first alloc
		plan = '{
			'{OP_ALLOC, 32'h0000_0000, 1'b1, 32'h0010_0000, 1'b0},
			'{OP_ALLOC, 32'hFFFF_FFFF, 1'b1, 32'h0010_1000, 1'b0},
			'{OP_FREE,  32'h0010_0000, 1'b0, 32'h0,        1'b0}, // handed-out frame
			'{OP_FREE,  32'h0010_0000, 1'b0, 32'h0,        1'b0}, // already free
			'{OP_FREE,  32'h000F_FFFF, 1'b0, 32'h0,        1'b0}, // one below base
			'{OP_FREE,  32'h0000_0000, 1'b0, 32'h0,        1'b0}, // lowest address
			'{OP_FREE,  32'h0020_0000, 1'b0, 32'h0,        1'b0}, // one past last frame
			'{OP_FREE,  32'hFFFF_FFFF, 1'b0, 32'h0,        1'b0}, // highest address
			'{OP_FREE,  32'h0010_5ABC, 1'b0, 32'h0,        1'b0}, // unaligned, in batch
			'{OP_FREE,  32'h001F_FFFF, 1'b0, 32'h0,        1'b0}, // last byte, last frame
			'{OP_ALLOC, 32'h0000_0000, 1'b1, 32'h0010_2000, 1'b0},
			'{OP_ALLOC, 32'h5555_5555, 1'b1, 32'h0010_3000, 1'b0},
			'{OP_ALLOC, 32'hAAAA_AAAA, 1'b1, 32'h0010_4000, 1'b0},
			'{OP_ALLOC, 32'h0000_0000, 1'b1, 32'h0010_5000, 1'b0}, // freed, still handed out
			'{OP_FREE,  32'h0010_0FFF, 1'b0, 32'h0,        1'b0}, // last byte of frame 0
			'{OP_ALLOC, 32'h0000_0000, 1'b1, 32'h0010_6000, 1'b0}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed table at the reset base, back to back
		for (r = 0; r < DIR_ROWS; r++) begin
			want.frame_address = plan[r].want_addr;
			want.out_of_frames = plan[r].want_oof;
			send_request(plan[r].op, plan[r].addr, plan[r].pinned, want);
		end

		// base at zero, no idling, one full drain in the middle
		write_heap_base(32'h0000_0000);
		run_phase(160, 0, 40, 80);

		// top base so addresses wrap; allocs only until the map runs dry
		write_heap_base(32'hFFFF_FFFF);
		sender_idle_pct = 58;
		oof_goal = oof_predicted + 3;
		for (r = 0; r < 400 && oof_predicted < oof_goal; r++)
			send_random_item(0);

		// random base, free-heavy to refill the map, light idling
		write_heap_base($urandom_range(32'hEFFF_FFFF));
		run_phase(120, 18, 65, -1);

		// back at the reset base with heavy idling
		write_heap_base(HEAP_BASE_RST);
		run_phase(120, 58, 40, -1);

		wait_drained(40);
		$display("run covered %0d allocs (%0d out of frames) and %0d frees over 5 heap bases",
			allocs_taken, oof_predicted, frees_taken);
		$display("%0d results checked, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/pfba_pkg.sv
sv/pfba_front.sv
sv/pfba_queue.sv
sv/pfba_back.sv
sv/page_frame_bitmap_allocator.sv
sim/tb.sv
